// File: src/kpmc_pkg.sv
// Shared types and constants for the k-way position merge chunker.
`timescale 1ns / 1ps

package kpmc_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_CHUNK_LEN      = 4'd0;
    localparam logic [3:0] CFG_ACTIVE_SOURCES = 4'd1;

    localparam logic [15:0] CHUNK_LEN_RESET      = 16'd1024;
    localparam logic [3:0]  ACTIVE_SOURCES_RESET = 4'd8;

    // Result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic [2:0]  source;
        logic        is_end;
        logic [30:0] ref_id;
        logic [31:0] position;
        logic [31:0] record_tag;
    } item_word_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  from_source;
        logic [30:0] out_ref_id;
        logic [31:0] out_position;
        logic [31:0] out_tag;
        logic [15:0] chunk_count;
        logic        chunk_last;
        logic [2:0]  refill_source;
    } result_word_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_item;
        logic scan_step;
        logic emit_record;
        logic emit_flush;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic any_empty;
        logic have_best;
        logic count_nonzero;
        logic out_free;
    } dp_stat_t;

endpackage

// File: src/kpmc_datapath.sv
// Datapath of the merge chunker: head store, minimum scan, chunk counter and result register.
`timescale 1ns / 1ps

module kpmc_datapath #(
    parameter int MAX_SOURCES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kpmc_pkg::item_word_t  item,
    output kpmc_pkg::result_word_t result,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  logic                  cfg_valid,
    input  logic [3:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  kpmc_pkg::ctl_cmd_t    cmd,
    output kpmc_pkg::dp_stat_t    stat
);
    import kpmc_pkg::*;

    localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    logic [15:0] chunk_len_reg;
    logic [3:0]  active_sources_reg;

    logic [MAX_SOURCES-1:0] head_full_reg;
    logic [MAX_SOURCES-1:0] head_ended_reg;
    logic [30:0] head_ref_reg [MAX_SOURCES];
    logic [31:0] head_pos_reg [MAX_SOURCES];
    logic [31:0] head_tag_reg [MAX_SOURCES];

    logic [15:0]      count_reg;
    logic [SRC_W-1:0] scan_idx_reg;
    logic             any_empty_reg;
    logic             have_best_reg;
    logic [SRC_W-1:0] best_idx_reg;
    logic [30:0]      best_ref_reg;
    logic [31:0]      best_pos_reg;
    logic [31:0]      best_tag_reg;

    logic         result_valid_reg;
    result_word_t result_reg;

    logic [7:0]       live_n;
    logic [SRC_W-1:0] live_last;
    logic             item_live;
    logic [SRC_W-1:0] item_idx;
    logic             entry_full;
    logic             entry_ended;
    logic             key_less;
    logic             take_best;
    logic [15:0]      count_next;
    logic             out_free;

    // Effective number of sources: zero acts as one, large values clip.
    always_comb
    begin
        if (active_sources_reg == 4'd0)
        begin
            live_n = 8'd1;
        end
        else if ({4'b0, active_sources_reg} > 8'(MAX_SOURCES))
        begin
            live_n = 8'(MAX_SOURCES);
        end
        else
        begin
            live_n = {4'b0, active_sources_reg};
        end
    end

    assign live_last  = SRC_W'(live_n - 8'd1);
    assign item_live  = ({5'b0, item.source} < live_n);
    assign item_idx   = SRC_W'(item.source);

    assign entry_full  = head_full_reg[scan_idx_reg];
    assign entry_ended = head_ended_reg[scan_idx_reg];
    assign key_less    = {head_ref_reg[scan_idx_reg], head_pos_reg[scan_idx_reg]}
                         < {best_ref_reg, best_pos_reg};
    // Strict compare over ascending indexes keeps ties with the lower source.
    assign take_best   = entry_full && (!have_best_reg || key_less);

    assign count_next = count_reg + 16'd1;
    assign out_free   = !result_valid_reg || !result_stall;

    assign stat.scan_last     = (scan_idx_reg == live_last);
    assign stat.any_empty     = any_empty_reg;
    assign stat.have_best     = have_best_reg;
    assign stat.count_nonzero = (count_reg != 16'd0);
    assign stat.out_free      = out_free;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_len_reg      <= CHUNK_LEN_RESET;
            active_sources_reg <= ACTIVE_SOURCES_RESET;
            head_full_reg      <= '0;
            head_ended_reg     <= '0;
            count_reg          <= 16'd0;
            scan_idx_reg       <= '0;
            any_empty_reg      <= 1'b0;
            have_best_reg      <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CHUNK_LEN:      chunk_len_reg <= cfg_data;
                    CFG_ACTIVE_SOURCES: active_sources_reg <= cfg_data[3:0];
                    default:            ;
                endcase
            end

            if (cmd.take_item)
            begin
                scan_idx_reg  <= '0;
                any_empty_reg <= 1'b0;
                have_best_reg <= 1'b0;
                if (item_live && !head_full_reg[item_idx] && !head_ended_reg[item_idx])
                begin
                    if (item.is_end)
                    begin
                        head_ended_reg[item_idx] <= 1'b1;
                    end
                    else
                    begin
                        head_full_reg[item_idx] <= 1'b1;
                    end
                end
            end

            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + SRC_W'(1);
                if (!entry_full && !entry_ended)
                begin
                    any_empty_reg <= 1'b1;
                end
                if (take_best)
                begin
                    have_best_reg <= 1'b1;
                end
            end

            if (cmd.emit_record)
            begin
                head_full_reg[best_idx_reg] <= 1'b0;
                count_reg <= (count_next == chunk_len_reg) ? 16'd0 : count_next;
            end
            else if (cmd.emit_flush)
            begin
                count_reg <= 16'd0;
            end

            if (cmd.emit_record || cmd.emit_flush)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && !item.is_end && item_live
            && !head_full_reg[item_idx] && !head_ended_reg[item_idx])
        begin
            head_ref_reg[item_idx] <= item.ref_id;
            head_pos_reg[item_idx] <= item.position;
            head_tag_reg[item_idx] <= item.record_tag;
        end

        if (cmd.scan_step && take_best)
        begin
            best_idx_reg <= scan_idx_reg;
            best_ref_reg <= head_ref_reg[scan_idx_reg];
            best_pos_reg <= head_pos_reg[scan_idx_reg];
            best_tag_reg <= head_tag_reg[scan_idx_reg];
        end

        if (cmd.emit_record)
        begin
            result_reg.kind          <= KIND_RECORD;
            result_reg.from_source   <= 3'(best_idx_reg);
            result_reg.out_ref_id    <= best_ref_reg;
            result_reg.out_position  <= best_pos_reg;
            result_reg.out_tag       <= best_tag_reg;
            result_reg.chunk_count   <= count_next;
            result_reg.chunk_last    <= (count_next == chunk_len_reg);
            result_reg.refill_source <= 3'(best_idx_reg);
        end
        else if (cmd.emit_flush)
        begin
            result_reg.kind          <= KIND_FLUSH;
            result_reg.from_source   <= 3'd0;
            result_reg.out_ref_id    <= 31'd0;
            result_reg.out_position  <= 32'd0;
            result_reg.out_tag       <= 32'd0;
            result_reg.chunk_count   <= count_reg;
            result_reg.chunk_last    <= 1'b1;
            result_reg.refill_source <= 3'd0;
        end
    end

endmodule

// File: src/kpmc_controller.sv
// Controller state machine of the merge chunker: sequences take, scan and emit.
`timescale 1ns / 1ps

module kpmc_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  kpmc_pkg::dp_stat_t stat,
    output kpmc_pkg::ctl_cmd_t cmd
);
    import kpmc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   item_stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.any_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.have_best)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_record = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (stat.count_nonzero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_flush = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign item_stall = item_stall_reg;

endmodule

// File: src/kway_position_merge_chunker.sv
// Top level of the k-way position merge chunker.
`timescale 1ns / 1ps

// Merges up to MAX_SOURCES sorted record streams by (reference index, position).
// Input words arrive on item/item_valid/item_stall; each one either fills the
// empty head of its source or marks that source ended. Once every active
// source holds a head or has ended, the smallest head is sent on
// result/result_valid/result_stall (ties go to the lower source number) and
// its source is named for refill. Records are counted into chunks of the
// programmed length, and the word that completes a chunk has chunk_last set.
// When all sources have ended, a flush word closes any partial chunk.
// Each input word passes a take step, a minimum scan that visits each active
// head in turn, and a decide step; item_stall holds off the next word until
// the decide step is done, and the result word leaves from a register.
// The result register parts the two sides: a waiting result does not stop
// the next word being taken, but a further result waits while result_stall
// holds the register, and item_stall stays high meanwhile.
// Reset empties every head, clears the chunk count and restores the chunk
// length to 1024 and active_sources to 8. Registers are written through the
// cfg port, always ready, by the user only while the block is idle (unenforced).
module kway_position_merge_chunker #(
    parameter int MAX_SOURCES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kpmc_pkg::item_word_t   item,
    input  logic                   item_valid,
    output logic                   item_stall,
    output kpmc_pkg::result_word_t result,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import kpmc_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Configuration writes land directly in the datapath registers, so the port never waits.
    assign cfg_ready = 1'b1;

    // The controller walks each word through take, scan and decide.
    kpmc_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath keeps the heads, the running minimum and the chunk count.
    kpmc_datapath #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
